FILE: src/lsrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared types for the segment-to-rectangle clipper pipeline.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  typedef struct packed {
    logic valid;
    logic visible;
  } lsrc_ctl_t;

endpackage

FILE: src/lsrc_seg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_seg_if
// Input channel: one segment and one rectangle per transaction.
// ----------------------------------------------------------------------------
interface lsrc_seg_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] rect_left;
  logic signed [W-1:0] rect_top;
  logic signed [W-1:0] rect_right;
  logic signed [W-1:0] rect_bottom;

  modport source (output valid, start_x, start_y, end_x, end_y,
                  rect_left, rect_top, rect_right, rect_bottom, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y,
                  rect_left, rect_top, rect_right, rect_bottom, output ready);
endinterface

FILE: src/lsrc_clip_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_clip_if
// Output channel: visible flag and clipped endpoints per transaction.
// ----------------------------------------------------------------------------
interface lsrc_clip_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic                visible;
  logic signed [W-1:0] clip_start_x;
  logic signed [W-1:0] clip_start_y;
  logic signed [W-1:0] clip_end_x;
  logic signed [W-1:0] clip_end_y;

  modport source (output valid, visible, clip_start_x, clip_start_y,
                  clip_end_x, clip_end_y, input ready);
  modport sink   (input valid, visible, clip_start_x, clip_start_y,
                  clip_end_x, clip_end_y, output ready);
endinterface

FILE: src/lsrc_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_setup
// Two stages: deltas and edge numerators, then per-axis entry/exit clamp.
// ----------------------------------------------------------------------------
module lsrc_setup #(
  parameter int W = 16,
  localparam int E = W + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  x0,
  input  logic signed [W-1:0]  y0,
  input  logic signed [W-1:0]  x1,
  input  logic signed [W-1:0]  y1,
  input  logic signed [W-1:0]  xl,
  input  logic signed [W-1:0]  yt,
  input  logic signed [W-1:0]  xr,
  input  logic signed [W-1:0]  yb,
  output lsrc_pkg::lsrc_ctl_t  ctl,
  output logic signed [E-1:0]  n0x,
  output logic signed [E-1:0]  n1x,
  output logic signed [E-1:0]  n0y,
  output logic signed [E-1:0]  n1y,
  output logic [W:0]           dnx,
  output logic [W:0]           dny,
  output logic signed [E-1:0]  dx,
  output logic signed [E-1:0]  dy,
  output logic signed [W-1:0]  bx,
  output logic signed [W-1:0]  by
);
  import lsrc_pkg::*;

  logic signed [E-1:0] ex0, ey0, ex1, ey1, exl, eyt, exr, eyb;
  logic signed [E-1:0] dx_next, dy_next, enx_next, exx_next, eny_next, exy_next;
  logic [W:0]          dxa_next, dya_next;
  logic                rej_next;

  lsrc_ctl_t           ctl1;
  logic signed [E-1:0] dx1, dy1, enx, exx, eny, exy;
  logic [W:0]          dxa, dya;
  logic signed [W-1:0] x0r, y0r;

  logic signed [E-1:0] n0x_next, n1x_next, n0y_next, n1y_next;
  logic [W:0]          dnx_next, dny_next;
  logic                rej2_next;

  always_comb begin
    ex0 = {{2{x0[W-1]}}, x0};
    ey0 = {{2{y0[W-1]}}, y0};
    ex1 = {{2{x1[W-1]}}, x1};
    ey1 = {{2{y1[W-1]}}, y1};
    exl = {{2{xl[W-1]}}, xl};
    eyt = {{2{yt[W-1]}}, yt};
    exr = {{2{xr[W-1]}}, xr};
    eyb = {{2{yb[W-1]}}, yb};
    dx_next  = ex1 - ex0;
    dy_next  = ey1 - ey0;
    dxa_next = dx_next[E-1] ? (W+1)'(0) - dx_next[W:0] : dx_next[W:0];
    dya_next = dy_next[E-1] ? (W+1)'(0) - dy_next[W:0] : dy_next[W:0];
    enx_next = dx_next[E-1] ? ex0 - exr : exl - ex0;
    exx_next = dx_next[E-1] ? ex0 - exl : exr - ex0;
    eny_next = dy_next[E-1] ? ey0 - eyb : eyt - ey0;
    exy_next = dy_next[E-1] ? ey0 - eyt : eyb - ey0;
    rej_next = ((dx_next == '0) && ((ex0 < exl) || (ex0 > exr))) ||
               ((dy_next == '0) && ((ey0 < eyt) || (ey0 > eyb)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (adv) begin
      ctl1.valid   <= in_valid;
      ctl1.visible <= !rej_next;
    end
    if (adv) begin
      dx1 <= dx_next;
      dy1 <= dy_next;
      dxa <= dxa_next;
      dya <= dya_next;
      enx <= enx_next;
      exx <= exx_next;
      eny <= eny_next;
      exy <= exy_next;
      x0r <= x0;
      y0r <= y0;
    end
  end

  always_comb begin
    if (dx1 == '0) begin
      n0x_next = '0;
      n1x_next = {{(E-1){1'b0}}, 1'b1};
      dnx_next = {{W{1'b0}}, 1'b1};
    end else begin
      n0x_next = (enx > 0) ? enx : '0;
      n1x_next = (exx < $signed({1'b0, dxa})) ? exx : $signed({1'b0, dxa});
      dnx_next = dxa;
    end
    if (dy1 == '0) begin
      n0y_next = '0;
      n1y_next = {{(E-1){1'b0}}, 1'b1};
      dny_next = {{W{1'b0}}, 1'b1};
    end else begin
      n0y_next = (eny > 0) ? eny : '0;
      n1y_next = (exy < $signed({1'b0, dya})) ? exy : $signed({1'b0, dya});
      dny_next = dya;
    end
    rej2_next = (n0x_next > n1x_next) || (n0y_next > n1y_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid   <= ctl1.valid;
      ctl.visible <= ctl1.visible && !rej2_next;
    end
    if (adv) begin
      n0x <= n0x_next;
      n1x <= n1x_next;
      n0y <= n0y_next;
      n1y <= n1y_next;
      dnx <= dnx_next;
      dny <= dny_next;
      dx  <= dx1;
      dy  <= dy1;
      bx  <= x0r;
      by  <= y0r;
    end
  end

endmodule

FILE: src/lsrc_param.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_param
// Cross products between axes, then entry/exit selection and overlap test.
// ----------------------------------------------------------------------------
module lsrc_param #(
  parameter int W = 16,
  localparam int E = W + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  lsrc_pkg::lsrc_ctl_t  ctl_in,
  input  logic signed [E-1:0]  n0x,
  input  logic signed [E-1:0]  n1x,
  input  logic signed [E-1:0]  n0y,
  input  logic signed [E-1:0]  n1y,
  input  logic [W:0]           dnx,
  input  logic [W:0]           dny,
  input  logic signed [E-1:0]  dx_in,
  input  logic signed [E-1:0]  dy_in,
  input  logic signed [W-1:0]  bx_in,
  input  logic signed [W-1:0]  by_in,
  output lsrc_pkg::lsrc_ctl_t  ctl,
  output logic [W:0]           t0n,
  output logic [W:0]           t0d,
  output logic [W:0]           t1n,
  output logic [W:0]           t1d,
  output logic signed [E-1:0]  dx,
  output logic signed [E-1:0]  dy,
  output logic signed [W-1:0]  bx,
  output logic signed [W-1:0]  by
);
  import lsrc_pkg::*;

  lsrc_ctl_t             ctl3;
  logic signed [2*E-1:0] pa, pb, pc, pd;
  logic signed [E-1:0]   n0x3, n1x3, n0y3, n1y3;
  logic [W:0]            dnx3, dny3;
  logic signed [E-1:0]   dx3, dy3;
  logic signed [W-1:0]   bx3, by3;
  logic                  t0_from_x, t1_from_x, rej_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (adv) begin
      ctl3 <= ctl_in;
    end
    if (adv) begin
      pa   <= n0x * $signed({1'b0, dny});
      pb   <= n0y * $signed({1'b0, dnx});
      pc   <= n1x * $signed({1'b0, dny});
      pd   <= n1y * $signed({1'b0, dnx});
      n0x3 <= n0x;
      n1x3 <= n1x;
      n0y3 <= n0y;
      n1y3 <= n1y;
      dnx3 <= dnx;
      dny3 <= dny;
      dx3  <= dx_in;
      dy3  <= dy_in;
      bx3  <= bx_in;
      by3  <= by_in;
    end
  end

  always_comb begin
    t0_from_x = pa > pb;
    t1_from_x = pc < pd;
    rej_next  = (pa > pd) || (pb > pc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid   <= ctl3.valid;
      ctl.visible <= ctl3.visible && !rej_next;
    end
    if (adv) begin
      t0n <= t0_from_x ? n0x3[W:0] : n0y3[W:0];
      t0d <= t0_from_x ? dnx3 : dny3;
      t1n <= t1_from_x ? n1x3[W:0] : n1y3[W:0];
      t1d <= t1_from_x ? dnx3 : dny3;
      dx  <= dx3;
      dy  <= dy3;
      bx  <= bx3;
      by  <= by3;
    end
  end

endmodule

FILE: src/lsrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_div
// One clipped coordinate: |dc|*num, pipelined restoring divide by den,
// then base plus signed quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lsrc_div #(
  parameter int W = 16,
  localparam int E  = W + 2,
  localparam int QW = W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  lsrc_pkg::lsrc_ctl_t  ctl_in,
  input  logic signed [W-1:0]  c0,
  input  logic signed [E-1:0]  dc,
  input  logic [W:0]           num,
  input  logic [W:0]           den,
  output lsrc_pkg::lsrc_ctl_t  ctl,
  output logic signed [W-1:0]  coord
);
  import lsrc_pkg::*;

  lsrc_ctl_t           sctl [QW+1];
  logic [W:0]          srem [QW+1];
  logic [QW-1:0]       slow [QW+1];
  logic [QW-1:0]       squo [QW+1];
  logic [W:0]          sden [QW+1];
  logic                sneg [QW+1];
  logic signed [W-1:0] sc0  [QW+1];

  logic [W:0]          mag;
  logic [2*QW-1:0]     prod;

  logic signed [E-1:0] qs, base, base_adj;

  always_comb begin
    mag  = dc[E-1] ? (W+1)'(0) - dc[W:0] : dc[W:0];
    prod = mag * num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sctl[0] <= '0;
    end else if (adv) begin
      sctl[0] <= ctl_in;
    end
    if (adv) begin
      srem[0] <= prod[2*QW-1:QW];
      slow[0] <= prod[QW-1:0];
      squo[0] <= '0;
      sden[0] <= den;
      sneg[0] <= dc[E-1] && (num != '0);
      sc0[0]  <= c0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [W+1:0] rem_sh;
    logic         ge;

    always_comb begin
      rem_sh = {srem[s], slow[s][QW-1]};
      ge     = rem_sh >= {1'b0, sden[s]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sctl[s+1] <= '0;
      end else if (adv) begin
        sctl[s+1] <= sctl[s];
      end
      if (adv) begin
        srem[s+1] <= ge ? (W+1)'(rem_sh - {1'b0, sden[s]}) : rem_sh[W:0];
        slow[s+1] <= {slow[s][QW-2:0], 1'b0};
        squo[s+1] <= {squo[s][QW-2:0], ge};
        sden[s+1] <= sden[s];
        sneg[s+1] <= sneg[s];
        sc0[s+1]  <= sc0[s];
      end
    end
  end

  always_comb begin
    qs   = sneg[QW] ? E'(0) - {1'b0, squo[QW]} : {1'b0, squo[QW]};
    base = {{2{sc0[QW][W-1]}}, sc0[QW]} + qs;
    base_adj = base;
    if (srem[QW] != '0) begin
      if (!sneg[QW] && base < 0) begin
        base_adj = base + {{(E-1){1'b0}}, 1'b1};
      end else if (sneg[QW] && base > 0) begin
        base_adj = base - {{(E-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= sctl[QW];
    end
    if (adv) begin
      coord <= sctl[QW].visible ? base_adj[W-1:0] : '0;
    end
  end

endmodule

FILE: src/line_segment_rect_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_rect_clip
// Liang-Barsky clip of a segment against an inclusive axis-aligned rectangle.
//
// seg  (sink):   one segment plus rectangle per transaction.
// clip (source): visible flag and clipped start/end points; all coordinates
//                are zero when the segment is rejected.
// Throughput: one transaction per cycle unless the receiver stalls. The
// restoring divider resolves one quotient bit per stage over
// COORD_WIDTH + 1 stages.
// The whole pipeline advances whenever the output register is empty or
// being taken; while the receiver stalls with a result held, seg.ready is
// low and every stage holds its contents.
// Reset clears all stage valid bits; no result is presented until a new
// transaction has passed through.
// ----------------------------------------------------------------------------
module line_segment_rect_clip #(
  parameter int COORD_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  lsrc_seg_if.sink     seg,
  lsrc_clip_if.source  clip
);
  import lsrc_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int E = W + 2;

  logic                adv;
  lsrc_ctl_t           ctl_s, ctl_p, ctl_o;
  logic signed [E-1:0] n0x, n1x, n0y, n1y, dx_s, dy_s, dx_p, dy_p;
  logic [W:0]          dnx, dny, t0n, t0d, t1n, t1d;
  logic signed [W-1:0] bx_s, by_s, bx_p, by_p;

  assign adv       = !clip.valid || clip.ready;
  assign seg.ready = adv;

  lsrc_setup #(.W(W)) u_setup (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(seg.valid),
    .x0(seg.start_x), .y0(seg.start_y), .x1(seg.end_x), .y1(seg.end_y),
    .xl(seg.rect_left), .yt(seg.rect_top), .xr(seg.rect_right),
    .yb(seg.rect_bottom),
    .ctl(ctl_s), .n0x(n0x), .n1x(n1x), .n0y(n0y), .n1y(n1y),
    .dnx(dnx), .dny(dny), .dx(dx_s), .dy(dy_s), .bx(bx_s), .by(by_s)
  );

  lsrc_param #(.W(W)) u_param (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_s),
    .n0x(n0x), .n1x(n1x), .n0y(n0y), .n1y(n1y), .dnx(dnx), .dny(dny),
    .dx_in(dx_s), .dy_in(dy_s), .bx_in(bx_s), .by_in(by_s),
    .ctl(ctl_p), .t0n(t0n), .t0d(t0d), .t1n(t1n), .t1d(t1d),
    .dx(dx_p), .dy(dy_p), .bx(bx_p), .by(by_p)
  );

  lsrc_div #(.W(W)) u_div_sx (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_p), .c0(bx_p), .dc(dx_p),
    .num(t0n), .den(t0d), .ctl(ctl_o), .coord(clip.clip_start_x)
  );

  lsrc_div #(.W(W)) u_div_sy (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_p), .c0(by_p), .dc(dy_p),
    .num(t0n), .den(t0d), .ctl(), .coord(clip.clip_start_y)
  );

  lsrc_div #(.W(W)) u_div_ex (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_p), .c0(bx_p), .dc(dx_p),
    .num(t1n), .den(t1d), .ctl(), .coord(clip.clip_end_x)
  );

  lsrc_div #(.W(W)) u_div_ey (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_p), .c0(by_p), .dc(dy_p),
    .num(t1n), .den(t1d), .ctl(), .coord(clip.clip_end_y)
  );

  assign clip.valid   = ctl_o.valid;
  assign clip.visible = ctl_o.visible;

endmodule

FILE: src/lsrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_checker
// Port-level checks for the clipper, bound to the top level.
// ----------------------------------------------------------------------------
module lsrc_checker #(
  parameter int W = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                visible,
  input logic signed [W-1:0] sx,
  input logic signed [W-1:0] sy,
  input logic signed [W-1:0] ex,
  input logic signed [W-1:0] ey
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> (sx == '0) && (sy == '0) && (ex == '0) && (ey == '0))
    else $error("rejected result carries nonzero coordinates");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output drain");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind line_segment_rect_clip lsrc_checker #(.W(COORD_WIDTH)) u_lsrc_checker (
  .clk(clk), .rst(rst), .in_ready(seg.ready), .out_valid(clip.valid),
  .out_ready(clip.ready), .visible(clip.visible), .sx(clip.clip_start_x),
  .sy(clip.clip_start_y), .ex(clip.clip_end_x), .ey(clip.clip_end_y)
);

FILE: test/lsrc_clip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_clip_checker
// Watches the segment and clip channels, computes the expected clip of every
// accepted segment with exact rational arithmetic and compares each result.
// ----------------------------------------------------------------------------
module lsrc_clip_checker #(
  parameter int W = 16
) (
  input  logic        clk,
  input  logic        rst,
  lsrc_seg_if.sink    seg,
  lsrc_clip_if.sink   clip,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic                visible;
    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
    logic signed [W-1:0] ex;
    logic signed [W-1:0] ey;
  } clip_res_t;

  clip_res_t clip_q[$];

  // floor-free truncation toward zero of c0 + num*dc/den
  function automatic longint trunc_point(longint c0, longint dc, longint num, longint den);
    longint p;
    longint qv;
    p = num * dc;
    qv = p / den;  // SV division truncates toward zero
    if (p % den != 0) begin
      if (p > 0 && c0 + qv < 0) qv = qv + 1;
      else if (p < 0 && c0 + qv > 0) qv = qv - 1;
    end
    return c0 + qv;
  endfunction

  function automatic clip_res_t clip_segment(longint x0, longint y0, longint x1,
                                            longint y1, longint xl, longint yt,
                                            longint xr, longint yb);
    clip_res_t r;
    longint p[4];
    longint q[4];
    longint an, ad, bn, bd;
    bit ok;
    an = 0; ad = 1; bn = 1; bd = 1; ok = 1;
    p[0] = x0 - x1; p[1] = x1 - x0; p[2] = y0 - y1; p[3] = y1 - y0;
    q[0] = x0 - xl; q[1] = xr - x0; q[2] = y0 - yt; q[3] = yb - y0;
    for (int i = 0; i < 4 && ok; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) ok = 0;
      end else begin
        if (p[i] < 0) begin
          if ((-q[i]) * ad > an * (-p[i])) begin
            an = -q[i]; ad = -p[i];
          end
        end else begin
          if (q[i] * bd < bn * p[i]) begin
            bn = q[i]; bd = p[i];
          end
        end
        if (an * bd > bn * ad) ok = 0;
      end
    end
    r = '0;
    if (ok) begin
      r.visible = 1'b1;
      r.sx = W'(trunc_point(x0, x1 - x0, an, ad));
      r.sy = W'(trunc_point(y0, y1 - y0, an, ad));
      r.ex = W'(trunc_point(x0, x1 - x0, bn, bd));
      r.ey = W'(trunc_point(y0, y1 - y0, bn, bd));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    clip_res_t want;
    clip_res_t got;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (seg.valid && seg.ready)
        clip_q.insert(clip_q.size(),
                      clip_segment(seg.start_x, seg.start_y, seg.end_x, seg.end_y,
                                   seg.rect_left, seg.rect_top, seg.rect_right,
                                   seg.rect_bottom));
      if (clip.valid && clip.ready) begin
        got = {clip.visible, clip.clip_start_x, clip.clip_start_y,
               clip.clip_end_x, clip.clip_end_y};
        if (clip_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = clip_q.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected vis=%b %0d,%0d %0d,%0d actual vis=%b %0d,%0d %0d,%0d",
                     $time, want.visible, want.sx, want.sy, want.ex, want.ey,
                     got.visible, got.sx, got.sy, got.ex, got.ey);
            errors <= errors + 1;
          end
        end
      end
      pending <= clip_q.size();
    end
  end

endmodule

FILE: test/tb_line_segment_rect_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_rect_clip
// Drives directed and random segment/rectangle pairs through the clipper
// under varying valid/ready pressure; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_line_segment_rect_clip;

  localparam int W = 16;
  localparam int LATENCY = W + 7;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle;
  int   recv_stall;
  bit   hold_recv;

  lsrc_seg_if  #(.W(W)) seg ();
  lsrc_clip_if #(.W(W)) clip ();

  line_segment_rect_clip #(.COORD_WIDTH(W)) dut (
    .clk  (clk),
    .rst  (rst),
    .seg  (seg.sink),
    .clip (clip.source)
  );

  lsrc_clip_checker #(.W(W)) checker_i (
    .clk     (clk),
    .rst     (rst),
    .seg     (seg.sink),
    .clip    (clip.sink),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_line_segment_rect_clip: FAIL");
    $finish;
  end

  // receiver
  always @(posedge clk) begin
    if (rst) clip.ready <= 1'b0;
    else if (hold_recv) clip.ready <= 1'b0;
    else clip.ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {1'b0, {(W-1){1'b1}}};
      1: return {1'b1, {(W-1){1'b0}}};
      2: return W'($urandom);
      default: return W'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic send_item(logic [W-1:0] sx, logic [W-1:0] sy, logic [W-1:0] ex,
                           logic [W-1:0] ey, logic [W-1:0] l, logic [W-1:0] t,
                           logic [W-1:0] r, logic [W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      seg.valid <= 1'b0;
      @(posedge clk);
    end
    seg.valid <= 1'b1;
    seg.start_x <= sx; seg.start_y <= sy; seg.end_x <= ex; seg.end_y <= ey;
    seg.rect_left <= l; seg.rect_top <= t; seg.rect_right <= r; seg.rect_bottom <= b;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [W-1:0] a, b2, c, d;
    a = rand_coord(); b2 = rand_coord(); c = rand_coord(); d = rand_coord();
    if ($urandom_range(9) < 7) begin
      // mostly well-formed rectangles
      if ($signed(a) > $signed(c)) {a, c} = {c, a};
      if ($signed(b2) > $signed(d)) {b2, d} = {d, b2};
    end
    if ($urandom_range(9) == 0)
      send_item(a, b2, a, $urandom_range(1) ? b2 : d, rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
    else
      send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), a, b2, c, d);
  endtask

  task automatic drain();
    seg.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  localparam logic [W-1:0] MX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MN = {1'b1, {(W-1){1'b0}}};

  initial begin
    rst = 1'b1;
    hold_recv = 0;
    send_idle = 0;
    recv_stall = 0;
    seg.valid = 1'b0;
    seg.start_x = '0; seg.start_y = '0; seg.end_x = '0; seg.end_y = '0;
    seg.rect_left = '0; seg.rect_top = '0; seg.rect_right = '0; seg.rect_bottom = '0;
    clip.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_item(0, 0, 100, 50, 10, 10, 60, 40);
    send_item(100, 50, 0, 0, 10, 10, 60, 40);
    send_item(MN, MN, MX, MX, MN, MN, MX, MX);
    send_item(MX, MN, MN, MX, -100, -100, 100, 100);
    send_item(MN, 0, MX, 0, 0, 0, 0, 0);
    send_item(5, 5, 5, 5, 0, 0, 10, 10);
    send_item(5, 5, 5, 5, 6, 0, 10, 10);
    send_item(10, 0, 10, 20, 10, 5, 30, 15);
    send_item(-5, 0, -5, 20, 0, 0, 10, 10);
    send_item(0, 20, 30, 20, 0, 0, 10, 10);
    send_item(0, 0, 10, 10, 10, 0, 0, 10);
    send_item(0, 0, 10, 10, 0, 10, 10, 0);
    send_item(-20, 0, 0, 20, 0, 0, 10, 10);
    send_item(-7, -3, 13, 9, -2, -1, 5, 4);
    send_item(MX, MX, MN, MN, 0, 0, 0, 0);
    send_item(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(MN, MN, MN, MN, MN, MN, MN, MN);
    send_item(MX, MX, MX, MX, MX, MX, MX, MX);
    drain();

    // receiver held off while sender keeps offering
    hold_recv = 1;
    fork
      begin repeat (200) @(posedge clk); hold_recv = 0; end
      repeat (60) send_random();
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 71; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 71; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      repeat (280) send_random();
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_line_segment_rect_clip: PASS");
    else
      $display("tb_line_segment_rect_clip: FAIL");
    $finish;
  end

endmodule
